/* rtl/core/bcdtod_pkg.sv */
// package: payload types, request codes and bcd arithmetic for the time-of-day counter
package bcdtod_pkg;

    localparam logic [3:0] REQ_ADVANCE  = 4'd0;
    localparam logic [3:0] REQ_SET_HRS  = 4'd1;
    localparam logic [3:0] REQ_SET_MIN  = 4'd2;
    localparam logic [3:0] REQ_SET_SEC  = 4'd3;
    localparam logic [3:0] REQ_INC_HRS  = 4'd4;
    localparam logic [3:0] REQ_DEC_HRS  = 4'd5;
    localparam logic [3:0] REQ_INC_MIN  = 4'd6;
    localparam logic [3:0] REQ_DEC_MIN  = 4'd7;
    localparam logic [3:0] REQ_INC_SEC  = 4'd8;
    localparam logic [3:0] REQ_DEC_SEC  = 4'd9;
    localparam logic [3:0] REQ_READ     = 4'd10;

    localparam logic [7:0] HOUR_LIMIT   = 8'h23;
    localparam logic [7:0] SIXTY_LIMIT  = 8'h59;
    localparam logic [7:0] BCD_MINUS1   = 8'h99;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] set_value;
    } req_t;

    typedef struct packed {
        logic [7:0] hours_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] seconds_bcd;
    } tod_t;

    // binary add followed by the classic decimal adjust
    function automatic logic [7:0] dec_adjust_sum(input logic [7:0] a, input logic [7:0] b);
        logic [9:0] s;
        logic       half;
        logic       carry;
        s     = {2'b00, a} + {2'b00, b};
        half  = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'h0f;
        carry = s[8];
        if ((s[3:0] > 4'd9) || half) begin
            s = s + 10'h006;
        end
        if ((s[8:0] > 9'h09f) || carry) begin
            s = s + 10'h060;
        end
        return s[7:0];
    endfunction

    function automatic logic inc_wraps(input logic [7:0] r, input logic [7:0] limit);
        logic [7:0] t;
        t = r + 8'd1;
        return t > limit;
    endfunction

    function automatic logic [7:0] bcd_inc(input logic [7:0] r, input logic [7:0] limit);
        return inc_wraps(r, limit) ? 8'h00 : dec_adjust_sum(r, 8'h01);
    endfunction

    function automatic logic [7:0] bcd_dec(input logic [7:0] r, input logic [7:0] limit);
        return (r == 8'h00) ? limit : dec_adjust_sum(r, BCD_MINUS1);
    endfunction

endpackage

/* rtl/core/bcdtod_step.sv */
// next-time logic: applies one request to the current time
module bcdtod_step (
    input  bcdtod_pkg::tod_t cur,
    input  bcdtod_pkg::req_t req,
    output bcdtod_pkg::tod_t nxt
);
    import bcdtod_pkg::*;

    logic sec_wrap;
    logic min_wrap;

    assign sec_wrap = inc_wraps(cur.seconds_bcd, SIXTY_LIMIT);
    assign min_wrap = inc_wraps(cur.minutes_bcd, SIXTY_LIMIT);

    always_comb begin
        nxt = cur;
        case (req.req_type)
            REQ_ADVANCE: begin
                nxt.seconds_bcd = bcd_inc(cur.seconds_bcd, SIXTY_LIMIT);
                // carry ripples only through wrapping fields
                if (sec_wrap) begin
                    nxt.minutes_bcd = bcd_inc(cur.minutes_bcd, SIXTY_LIMIT);
                    if (min_wrap) begin
                        nxt.hours_bcd = bcd_inc(cur.hours_bcd, HOUR_LIMIT);
                    end
                end
            end
            REQ_SET_HRS: nxt.hours_bcd   = req.set_value;
            REQ_SET_MIN: nxt.minutes_bcd = req.set_value;
            REQ_SET_SEC: nxt.seconds_bcd = req.set_value;
            REQ_INC_HRS: nxt.hours_bcd   = bcd_inc(cur.hours_bcd, HOUR_LIMIT);
            REQ_DEC_HRS: nxt.hours_bcd   = bcd_dec(cur.hours_bcd, HOUR_LIMIT);
            REQ_INC_MIN: nxt.minutes_bcd = bcd_inc(cur.minutes_bcd, SIXTY_LIMIT);
            REQ_DEC_MIN: nxt.minutes_bcd = bcd_dec(cur.minutes_bcd, SIXTY_LIMIT);
            REQ_INC_SEC: nxt.seconds_bcd = bcd_inc(cur.seconds_bcd, SIXTY_LIMIT);
            REQ_DEC_SEC: nxt.seconds_bcd = bcd_dec(cur.seconds_bcd, SIXTY_LIMIT);
            default: nxt = cur;
        endcase
    end

endmodule

/* rtl/core/bcd_time_of_day_counter.sv */
// top level: 24-hour packed-bcd time-of-day counter with request/result channels
//
// Usage:
//   s_valid/s_ready/s_payload carry requests: advance one second, set a field,
//   step a field up or down with bcd wrap and no carry, or read.
//   m_valid/m_ready/m_payload return one result per request: the time after it.
//   A request is registered on acceptance and applied once the result stage is
//   free, which updates the time register that also drives m_payload. The result
//   is valid once its request has been applied to the time register.
//   Throughput: one request per cycle while m_ready stays high.
//   When the receiver stalls the result and the time hold; one more request is
//   taken into the input register, then s_ready drops until the result leaves.
//   Reset (aresetn low, synchronous) sets the time to 00:00:00 and empties
//   both stages.
module bcd_time_of_day_counter (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bcdtod_pkg::req_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output bcdtod_pkg::tod_t m_payload
);
    import bcdtod_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    req_t in_req_reg;
    logic m_valid_reg;
    logic m_valid_next;
    tod_t time_reg;
    tod_t time_next;
    logic out_free;
    logic apply;

    assign out_free = !m_valid_reg || m_ready;
    assign apply    = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    bcdtod_step u_step (
        .cur (time_reg),
        .req (in_req_reg),
        .nxt (time_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (apply) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (apply) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            time_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (apply) begin
                time_reg <= time_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_payload;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = time_reg;

    // a stalled result must not be overwritten by the next request
    a_stall_holds_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> $stable(time_reg))
        else $error("time changed while result stalled");

    // a read request leaves the time alone
    a_read_keeps_time: assert property (@(posedge aclk) disable iff (!aresetn)
        apply && in_req_reg.req_type == REQ_READ |=> $stable(time_reg) && m_valid_reg)
        else $error("read request changed the time");

    // s_ready only drops when the input register is occupied and blocked
    a_ready_low_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("request refused with room available");

    // an applied request always yields a result in the next cycle
    a_apply_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        apply |=> m_valid_reg)
        else $error("applied request produced no result");

endmodule

/* test/bcd_time_of_day_counter_test.sv */
// testbench: bcd time-of-day counter checked against a cycle-free predictor of the clock
`timescale 1ns / 1ps

module bcd_time_of_day_counter_test;
    import bcdtod_pkg::*;

    localparam logic [3:0] REQ_CODE_MAX = 4'd15;
    localparam int ITEMS_PER_PHASE = 567;

    typedef struct {
        req_t req;
        int   phase;
    } queued_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    tod_t m_payload;

    queued_req_t req_backlog[$];
    tod_t        tod_expected[$];
    tod_t        tod_model = '0;
    int          recv_phase = 0;
    int          mismatch_count = 0;

    int unsigned send_idle_pct[3] = '{26, 80, 0};
    int unsigned recv_idle_pct[3] = '{80, 26, 0};

    bcd_time_of_day_counter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #10 aclk = ~aclk;

    // 8-bit add with decimal adjust, applied literally even to non-bcd operands
    function automatic logic [7:0] bcd_adjusted_sum(input logic [7:0] a, input logic [7:0] b);
        logic [9:0] s;
        logic       half_cy;
        logic       full_cy;
        s       = {2'b00, a} + {2'b00, b};
        half_cy = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'h0f;
        full_cy = s[8];
        if ((s[3:0] > 4'd9) || half_cy) begin
            s = s + 10'h006;
        end
        if ((s[8:0] > 9'h09f) || full_cy) begin
            s = s + 10'h060;
        end
        return s[7:0];
    endfunction

    // returns 1 when the field rolled over to zero
    function automatic logic field_step_up(inout logic [7:0] field, input logic [7:0] limit);
        logic [7:0] next_raw;
        next_raw = field + 8'd1;
        if (next_raw > limit) begin
            field = 8'h00;
            return 1'b1;
        end
        field = bcd_adjusted_sum(field, 8'h01);
        return 1'b0;
    endfunction

    function automatic logic [7:0] field_step_down(input logic [7:0] field,
                                                   input logic [7:0] limit);
        return (field == 8'h00) ? limit : bcd_adjusted_sum(field, BCD_MINUS1);
    endfunction

    function automatic void update_tod_model(input req_t rq);
        logic [7:0] hh;
        logic [7:0] mm;
        logic [7:0] ss;
        logic       wrap;
        hh = tod_model.hours_bcd;
        mm = tod_model.minutes_bcd;
        ss = tod_model.seconds_bcd;
        case (rq.req_type)
            REQ_ADVANCE: begin
                wrap = field_step_up(ss, SIXTY_LIMIT);
                if (wrap) begin
                    wrap = field_step_up(mm, SIXTY_LIMIT);
                    if (wrap) begin
                        wrap = field_step_up(hh, HOUR_LIMIT);
                    end
                end
            end
            REQ_SET_HRS: hh = rq.set_value;
            REQ_SET_MIN: mm = rq.set_value;
            REQ_SET_SEC: ss = rq.set_value;
            REQ_INC_HRS: wrap = field_step_up(hh, HOUR_LIMIT);
            REQ_DEC_HRS: hh = field_step_down(hh, HOUR_LIMIT);
            REQ_INC_MIN: wrap = field_step_up(mm, SIXTY_LIMIT);
            REQ_DEC_MIN: mm = field_step_down(mm, SIXTY_LIMIT);
            REQ_INC_SEC: wrap = field_step_up(ss, SIXTY_LIMIT);
            REQ_DEC_SEC: ss = field_step_down(ss, SIXTY_LIMIT);
            default: ;
        endcase
        tod_model.hours_bcd   = hh;
        tod_model.minutes_bcd = mm;
        tod_model.seconds_bcd = ss;
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned d);
        logic [7:0] b;
        b[7:4] = 4'(d / 10);
        b[3:0] = 4'(d % 10);
        return b;
    endfunction

    task automatic queue_req(input logic [3:0] code, input logic [7:0] value, input int phase);
        queued_req_t item;
        item.req.req_type  = code;
        item.req.set_value = value;
        item.phase         = phase;
        req_backlog.push_back(item);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // request driver: predicts on acceptance, then offers the next pending request
    always @(posedge aclk) begin : request_driver
        queued_req_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                update_tod_model(s_payload);
                tod_expected.push_back(tod_model);
            end
            if (req_backlog.size() != 0 &&
                $urandom_range(99) >= send_idle_pct[req_backlog[0].phase]) begin
                item = req_backlog.pop_front();
                s_payload  <= item.req;
                s_valid    <= 1'b1;
                recv_phase <= item.phase;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        tod_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tod_expected.size() == 0) begin
                    $error("result %h with no request outstanding", m_payload);
                    mismatch_count++;
                end else begin
                    want = tod_expected.pop_front();
                    check_field("hours_bcd", want.hours_bcd, m_payload.hours_bcd);
                    check_field("minutes_bcd", want.minutes_bcd, m_payload.minutes_bcd);
                    check_field("seconds_bcd", want.seconds_bcd, m_payload.seconds_bcd);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct[recv_phase]);
        end
    end

    initial begin
        #20_000_000;
        $display("bcd_time_of_day_counter test failed");
        $finish;
    end

    initial begin : stimulus
        int          count;
        int unsigned pick;
        int unsigned n_adv;
        logic [3:0]  ofs;

        // directed: wraps at both ends, every request, invalid bcd, unused codes
        queue_req(REQ_READ, 8'h00, 0);
        queue_req(REQ_DEC_SEC, 8'hff, 0);
        queue_req(REQ_ADVANCE, 8'h00, 0);
        queue_req(REQ_DEC_HRS, 8'h00, 0);
        queue_req(REQ_SET_MIN, 8'h59, 0);
        queue_req(REQ_SET_SEC, 8'h59, 0);
        queue_req(REQ_ADVANCE, 8'hff, 0);
        queue_req(REQ_SET_HRS, 8'h23, 0);
        queue_req(REQ_INC_HRS, 8'h00, 0);
        queue_req(REQ_INC_MIN, 8'h00, 0);
        queue_req(REQ_DEC_MIN, 8'h00, 0);
        queue_req(REQ_DEC_MIN, 8'h00, 0);
        queue_req(REQ_INC_MIN, 8'h00, 0);
        queue_req(REQ_INC_SEC, 8'h00, 0);
        queue_req(REQ_DEC_SEC, 8'h00, 0);
        queue_req(REQ_SET_HRS, 8'hff, 0);
        queue_req(REQ_INC_HRS, 8'h00, 0);
        queue_req(REQ_DEC_HRS, 8'h00, 0);
        queue_req(REQ_SET_MIN, 8'h3a, 0);
        queue_req(REQ_INC_MIN, 8'h00, 0);
        queue_req(REQ_DEC_MIN, 8'h00, 0);
        queue_req(REQ_SET_SEC, 8'h00, 0);
        queue_req(REQ_READ + 4'd1, 8'hff, 0);
        queue_req(REQ_CODE_MAX, 8'hff, 0);
        queue_req(REQ_ADVANCE, 8'haa, 0);

        for (int phase = 0; phase < 3; phase++) begin
            count = 0;
            while (count < ITEMS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    // park the clock just short of a carry, then tick toward it and often through it
                    queue_req(REQ_SET_HRS, $urandom_range(1) ? 8'h23 : to_bcd($urandom_range(23)),
                              phase);
                    queue_req(REQ_SET_MIN, $urandom_range(1) ? 8'h59 : to_bcd($urandom_range(59)),
                              phase);
                    queue_req(REQ_SET_SEC, to_bcd($urandom_range(59, 55)), phase);
                    n_adv = $urandom_range(6, 1);
                    repeat (n_adv) queue_req(REQ_ADVANCE, 8'($urandom_range(255)), phase);
                    count += 3 + n_adv;
                end else begin
                    if (pick < 40) begin
                        queue_req(REQ_ADVANCE, 8'($urandom_range(255)), phase);
                    end else if (pick < 50) begin
                        ofs = 4'($urandom_range(2));
                        queue_req(REQ_SET_HRS + ofs,
                                  to_bcd(ofs == 4'd0 ? $urandom_range(23) : $urandom_range(59)),
                                  phase);
                    end else if (pick < 56) begin
                        ofs = 4'($urandom_range(2));
                        queue_req(REQ_SET_HRS + ofs, 8'($urandom_range(255)), phase);
                    end else if (pick < 88) begin
                        ofs = 4'($urandom_range(5));
                        queue_req(REQ_INC_HRS + ofs, 8'($urandom_range(255)), phase);
                    end else if (pick < 94) begin
                        queue_req(REQ_READ, 8'($urandom_range(255)), phase);
                    end else begin
                        queue_req(4'($urandom_range(REQ_CODE_MAX, REQ_READ + 4'd1)),
                                  8'($urandom_range(255)), phase);
                    end
                    count++;
                end
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_backlog.size() != 0 || s_valid || tod_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("bcd_time_of_day_counter test passed");
        end else begin
            $display("bcd_time_of_day_counter test failed");
        end
        $finish;
    end

endmodule
